### hdl/lbct_pkg.sv
// Package of shared types and constants for the block cache tag unit.
`default_nettype none

package lbct_pkg;

  localparam int unsigned AddrW     = 24;
  localparam int unsigned VolW      = 8;
  localparam int unsigned EntryOutW = 6;
  localparam int unsigned InBlkW    = 12;

  typedef struct packed {
    logic [VolW-1:0]  volume_id;
    logic [AddrW-1:0] byte_offset;
    logic             fill_ok;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [EntryOutW-1:0] entry_index;
    logic                 entry_valid;
    logic                 evicted;
    logic [VolW-1:0]      evicted_volume;
    logic [AddrW-1:0]     evicted_block;
    logic [AddrW-1:0]     block_start;
    logic [InBlkW-1:0]    offset_in_block;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [VolW-1:0]  volume;
    logic [AddrW-1:0] block;
  } tag_t;

  typedef struct packed {
    logic init_wr;
    logic accept;
    logic prep;
    logic scan;
    logic vic_rd;
    logic vic_wr;
    logic link_rd;
    logic unhook;
    logic append;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic scan_hit;
    logic scan_end;
    logic fill;
    logic idx_is_tail;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hdl/lru_block_cache_tags_unit.sv
// Top level of the block cache tag unit: fully associative lookup with LRU replacement.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o    in_data_i   (req_t)
//   out       output     out_valid_o/out_ready_i  out_data_o  (rsp_t)
//   cfg       input      cfg_we_i                 cfg_wdata_i (block base)
//
// The tag scan is sequential, one stored entry read per cycle: a hit ends it
// at the matching entry, while a miss reads every entry before the victim,
// the LRU head, is read and rewritten.
// After reset a clearing pass writes every entry of the tag and link stores;
// no request is taken during it, register writes are.
// The result register holds a finished result while the next request is
// taken; a stalled output holds the engine only at its final step.
`default_nettype none

module lru_block_cache_tags_unit
  import lbct_pkg::*;
#(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [AddrW-1:0] cfg_wdata_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output rsp_t             out_data_o
);

  cmd_t cmd;
  sts_t sts;

  lbct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbct_datapath #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### hdl/lbct_ctrl.sv
// Sequencing state machine of the block cache tag unit.
`default_nettype none

module lbct_ctrl
  import lbct_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    StInit   = 10'b0000000001,
    StIdle   = 10'b0000000010,
    StPrep   = 10'b0000000100,
    StScan   = 10'b0000001000,
    StVicRd  = 10'b0000010000,
    StVicWr  = 10'b0000100000,
    StLinkRd = 10'b0001000000,
    StUnhook = 10'b0010000000,
    StAppend = 10'b0100000000,
    StFinish = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StInit: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = StLinkRd;
        end else if (sts_i.scan_end) begin
          state_d = StVicRd;
        end
      end
      StVicRd: begin
        cmd_o.vic_rd = 1'b1;
        state_d      = StVicWr;
      end
      StVicWr: begin
        cmd_o.vic_wr = 1'b1;
        state_d      = sts_i.fill ? StLinkRd : StFinish;
      end
      StLinkRd: begin
        cmd_o.link_rd = 1'b1;
        state_d       = sts_i.idx_is_tail ? StFinish : StUnhook;
      end
      StUnhook: begin
        cmd_o.unhook = 1'b1;
        state_d      = StAppend;
      end
      StAppend: begin
        cmd_o.append = 1'b1;
        state_d      = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StInit;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StPrep)
    else $error("transfer accepted without entering preparation");

  a_append_after_unhook: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StAppend |-> $past(state_q) == StUnhook)
    else $error("append without unhook");

  a_vic_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.vic_wr |-> $past(cmd_o.vic_rd))
    else $error("victim write without victim read");

endmodule

`default_nettype wire

### hdl/lbct_datapath.sv
// Tag store, LRU link stores and result register of the block cache tag unit.
`default_nettype none

module lbct_datapath
  import lbct_pkg::*;
#(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [AddrW-1:0] cfg_wdata_i,
  input  req_t             in_data_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output rsp_t             out_data_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0]  IdxLast = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0]  CntEnd  = CntW'(ENTRIES);
  localparam logic [AddrW-1:0] OffMask = AddrW'(BLOCK_BYTES - 1);

  tag_t            tag_mem   [ENTRIES];
  logic [IdxW-1:0] older_mem [ENTRIES];
  logic [IdxW-1:0] newer_mem [ENTRIES];

  logic [AddrW-1:0] base_q;
  logic [VolW-1:0]  vol_q;
  logic [AddrW-1:0] dist_q;
  logic             fill_q;
  logic [AddrW-1:0] block_q;
  logic [InBlkW-1:0] inblk_q;
  logic [CntW-1:0]  scan_cnt_q;
  logic             rd_pend_q;
  logic [IdxW-1:0]  rd_idx_q;
  tag_t             tag_rd_q;
  logic [IdxW-1:0]  older_rd_q, newer_rd_q;
  logic [IdxW-1:0]  idx_q, head_q, tail_q, init_cnt_q;
  logic             hit_q, ev_q;
  logic [VolW-1:0]  ev_vol_q;
  logic [AddrW-1:0] ev_blk_q;
  rsp_t             out_q;
  logic             out_valid_q;

  logic             match, scan_issue, unhook_mid;
  logic             tag_we, tag_re;
  logic [IdxW-1:0]  tag_waddr, tag_raddr;
  tag_t             tag_wdata;
  logic             older_we, newer_we;
  logic [IdxW-1:0]  older_waddr, older_wdata, newer_waddr, newer_wdata;

  always_comb begin
    match = rd_pend_q && tag_rd_q.valid && (tag_rd_q.volume == vol_q)
            && (tag_rd_q.block == block_q);
    scan_issue = cmd_i.scan && (scan_cnt_q != CntEnd);
    unhook_mid = cmd_i.unhook && (idx_q != head_q);

    tag_we    = cmd_i.init_wr || cmd_i.vic_wr;
    tag_waddr = cmd_i.init_wr ? init_cnt_q : idx_q;
    tag_wdata = cmd_i.init_wr ? tag_t'('0)
                              : tag_t'{valid: fill_q, volume: vol_q, block: block_q};
    tag_re    = scan_issue || cmd_i.vic_rd;
    tag_raddr = cmd_i.vic_rd ? head_q : scan_cnt_q[IdxW-1:0];

    older_we = cmd_i.init_wr || unhook_mid || cmd_i.append;
    newer_we = older_we;
    if (cmd_i.init_wr) begin
      older_waddr = init_cnt_q;
      older_wdata = (init_cnt_q == '0) ? IdxLast : init_cnt_q - IdxW'(1);
      newer_waddr = init_cnt_q;
      newer_wdata = (init_cnt_q == IdxLast) ? '0 : init_cnt_q + IdxW'(1);
    end else if (cmd_i.unhook) begin
      older_waddr = newer_rd_q;
      older_wdata = older_rd_q;
      newer_waddr = older_rd_q;
      newer_wdata = newer_rd_q;
    end else begin
      older_waddr = idx_q;
      older_wdata = tail_q;
      newer_waddr = tail_q;
      newer_wdata = idx_q;
    end

    sts_o.init_last   = (init_cnt_q == IdxLast);
    sts_o.scan_hit    = match;
    sts_o.scan_end    = rd_pend_q && !match && (rd_idx_q == IdxLast);
    sts_o.fill        = fill_q;
    sts_o.idx_is_tail = (idx_q == tail_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rd_q <= tag_mem[tag_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (older_we) begin
      older_mem[older_waddr] <= older_wdata;
    end
    if (newer_we) begin
      newer_mem[newer_waddr] <= newer_wdata;
    end
    if (cmd_i.link_rd) begin
      older_rd_q <= older_mem[idx_q];
      newer_rd_q <= newer_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      init_cnt_q  <= '0;
      head_q      <= '0;
      tail_q      <= IdxLast;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_cnt_q + IdxW'(1);
      end
      if (cmd_i.unhook && (idx_q == head_q)) begin
        head_q <= newer_rd_q;
      end
      if (cmd_i.append) begin
        tail_q <= idx_q;
      end
      rd_pend_q <= scan_issue;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vol_q  <= in_data_i.volume_id;
      dist_q <= in_data_i.byte_offset - base_q;
      fill_q <= in_data_i.fill_ok;
    end
    if (cmd_i.prep) begin
      block_q    <= (dist_q & ~OffMask) + base_q;
      inblk_q    <= InBlkW'(dist_q & OffMask);
      scan_cnt_q <= '0;
      hit_q      <= 1'b0;
      ev_q       <= 1'b0;
      ev_vol_q   <= '0;
      ev_blk_q   <= '0;
    end
    if (scan_issue) begin
      scan_cnt_q <= scan_cnt_q + CntW'(1);
      rd_idx_q   <= scan_cnt_q[IdxW-1:0];
    end
    if (cmd_i.scan && match) begin
      hit_q <= 1'b1;
      idx_q <= rd_idx_q;
    end
    if (cmd_i.vic_rd) begin
      idx_q <= head_q;
    end
    if (cmd_i.vic_wr) begin
      ev_q     <= tag_rd_q.valid;
      ev_vol_q <= tag_rd_q.valid ? tag_rd_q.volume : '0;
      ev_blk_q <= tag_rd_q.valid ? tag_rd_q.block : '0;
    end
    if (cmd_i.load_out) begin
      out_q <= '{hit:             hit_q,
                 entry_index:     EntryOutW'(idx_q),
                 entry_valid:     hit_q || fill_q,
                 evicted:         ev_q,
                 evicted_volume:  ev_vol_q,
                 evicted_block:   ev_blk_q,
                 block_start:     block_q,
                 offset_in_block: inblk_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_head_not_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q != tail_q)
    else $error("LRU head and MRU tail coincide");

  a_vic_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vic_wr |-> !hit_q)
    else $error("victim written on a hit");

  a_append_not_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> idx_q != tail_q)
    else $error("tail entry appended to itself");

endmodule

`default_nettype wire

### tb/tb_lru_block_cache_tags_unit.sv
// Self-checking bench for the block cache tag unit: LRU lookup predictor, random traffic, stalls.
module tb_lru_block_cache_tags_unit;
  import lbct_pkg::*;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned BLOCK_BYTES = 4096;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [AddrW-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  req_t             in_data;
  logic             out_valid;
  logic             out_ready;
  rsp_t             out_data;

  lru_block_cache_tags_unit #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  req_t        lookup_q[$];
  rsp_t        answer_q[$];
  int          lookups_owed = 0;
  int          fails = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold = 1'b0;
  bit          in_taken = 1'b0;
  logic [AddrW-1:0] cur_base = '0;

  logic [VolW-1:0]  shadow_vol   [ENTRIES];
  logic [AddrW-1:0] shadow_blk   [ENTRIES];
  bit               shadow_valid [ENTRIES];
  int unsigned      older_of     [ENTRIES];
  int unsigned      newer_of     [ENTRIES];
  int unsigned      lru_idx;
  int unsigned      mru_idx;
  logic [AddrW-1:0] shadow_base;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void shadow_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_vol[i]   = '0;
      shadow_blk[i]   = '0;
      shadow_valid[i] = 1'b0;
      older_of[i]     = (i + ENTRIES - 1) % ENTRIES;
      newer_of[i]     = (i + 1) % ENTRIES;
    end
    lru_idx     = 0;
    mru_idx     = ENTRIES - 1;
    shadow_base = '0;
  endfunction

  function automatic void promote(int unsigned idx);
    if (idx == mru_idx) return;
    if (idx == lru_idx) begin
      lru_idx = newer_of[idx];
    end else begin
      newer_of[older_of[idx]] = newer_of[idx];
      older_of[newer_of[idx]] = older_of[idx];
    end
    older_of[idx]     = mru_idx;
    newer_of[mru_idx] = idx;
    mru_idx           = idx;
  endfunction

  function automatic rsp_t cache_lookup(req_t rq);
    logic [AddrW-1:0] span;
    logic [AddrW-1:0] aligned;
    logic [AddrW-1:0] bstart;
    int unsigned      idx;
    bit               found;
    rsp_t             r;
    span    = rq.byte_offset - shadow_base;
    aligned = AddrW'((span / BLOCK_BYTES) * BLOCK_BYTES);
    bstart  = aligned + shadow_base;
    r = '0;
    r.block_start     = bstart;
    r.offset_in_block = InBlkW'(span - aligned);
    found = 1'b0;
    idx   = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && shadow_valid[i] && shadow_vol[i] == rq.volume_id &&
          shadow_blk[i] == bstart) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      promote(idx);
      r.hit         = 1'b1;
      r.entry_valid = 1'b1;
    end else begin
      idx = lru_idx;
      if (shadow_valid[idx]) begin
        r.evicted        = 1'b1;
        r.evicted_volume = shadow_vol[idx];
        r.evicted_block  = shadow_blk[idx];
      end
      shadow_valid[idx] = 1'b0;
      if (rq.fill_ok) begin
        shadow_vol[idx]   = rq.volume_id;
        shadow_blk[idx]   = bstart;
        shadow_valid[idx] = 1'b1;
        promote(idx);
      end
      r.entry_valid = rq.fill_ok;
    end
    r.entry_index = EntryOutW'(idx);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 10) $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Sample transfers and config writes at the rising edge.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (cfg_we) shadow_base = cfg_wdata;
    if (in_valid && in_ready) begin
      answer_q.push_back(cache_lookup(in_data));
      lookups_owed--;
      in_taken = 1'b1;
    end
    if (out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result transfer: %0h", out_data);
      end else begin
        want = answer_q.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_data.hit));
        check_field("entry_index", 32'(want.entry_index), 32'(out_data.entry_index));
        check_field("entry_valid", 32'(want.entry_valid), 32'(out_data.entry_valid));
        check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
        check_field("evicted_volume", 32'(want.evicted_volume),
                    32'(out_data.evicted_volume));
        check_field("evicted_block", 32'(want.evicted_block),
                    32'(out_data.evicted_block));
        check_field("block_start", 32'(want.block_start), 32'(out_data.block_start));
        check_field("offset_in_block", 32'(want.offset_in_block),
                    32'(out_data.offset_in_block));
      end
    end
  end

  // Advance the request channel and the result ready at the falling edge.
  always @(negedge clk) begin : driver
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (lookup_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= lookup_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_lookup(logic [VolW-1:0] vol, logic [AddrW-1:0] off, logic fill);
    req_t rq;
    rq.volume_id   = vol;
    rq.byte_offset = off;
    rq.fill_ok     = fill;
    lookup_q.push_back(rq);
    lookups_owed++;
  endtask

  task automatic queue_random(int n, int unsigned pool_n);
    logic [VolW-1:0]  pool_vol [128];
    logic [AddrW-1:0] pool_blk [128];
    int unsigned      k;
    logic [AddrW-1:0] off;
    for (int i = 0; i < 128; i++) begin
      pool_vol[i] = VolW'($urandom_range(255));
      pool_blk[i] = AddrW'($urandom_range(4095));
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        k   = $urandom_range(pool_n - 1);
        off = AddrW'(cur_base + pool_blk[k] * BLOCK_BYTES
                     + $urandom_range(BLOCK_BYTES - 1));
        queue_lookup(pool_vol[k], off, $urandom_range(9) != 0);
      end else begin
        queue_lookup(VolW'($urandom_range(255)), AddrW'($urandom_range(24'hFFFFFF)),
                     1'($urandom_range(1)));
      end
    end
  endtask

  task automatic write_base(logic [AddrW-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    cur_base  = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (lookups_owed != 0 || answer_q.size() != 0);
    repeat (ENTRIES + 20) @(negedge clk);
  endtask

  initial begin
    shadow_reset();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 65;
    write_base(24'h000000);
    queue_lookup(8'h00, 24'h000000, 1'b1);
    queue_lookup(8'h00, 24'h000FFF, 1'b1);
    queue_lookup(8'hFF, 24'hFFFFFF, 1'b1);
    queue_lookup(8'hFF, 24'hFFF000, 1'b0);
    queue_lookup(8'h01, 24'h001000, 1'b0);
    queue_lookup(8'h01, 24'h001000, 1'b1);
    queue_lookup(8'h01, 24'h000000, 1'b1);
    queue_lookup(8'h00, 24'h000800, 1'b0);
    queue_lookup(8'hAA, 24'h555555, 1'b1);
    queue_lookup(8'h55, 24'hAAAAAA, 1'b0);
    wait_drained();

    write_base(24'h000800);
    queue_random(300, 96);
    // hold off the receiver so the unit backs up and stalls its input
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk);
    rx_hold <= 1'b0;
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 33;
    write_base(24'hFFFFFF);
    queue_lookup(8'h00, 24'h000000, 1'b1);
    queue_lookup(8'h00, 24'hFFFFFF, 1'b1);
    queue_lookup(8'h07, 24'h000FFE, 1'b1);
    queue_lookup(8'h07, 24'h000FFF, 1'b1);
    queue_random(300, 48);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_base(AddrW'($urandom_range(24'hFFFFFF)));
    queue_random(350, 80);
    wait_drained();

    write_base(24'h000FFF);
    queue_random(60, 128);
    wait_drained();

    if (fails == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule
